@@ design/lcb_pkg.sv @@
package lcb_pkg;

    // Sizing of the frame store
    localparam int MAX_FADE_FRAMES  = 5;
    localparam int FRAME_PIXELS_MAX = 65536;
    localparam int STORE_DEPTH      = MAX_FADE_FRAMES * FRAME_PIXELS_MAX;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int PIX_IDX_W        = $clog2(FRAME_PIXELS_MAX);
    localparam int SIZE_W           = $clog2(FRAME_PIXELS_MAX + 1);
    localparam int FADE_W           = $clog2(MAX_FADE_FRAMES + 1);

    // Pixel and weight formats
    localparam int CH_W     = 8;
    localparam int PIXEL_W  = 3 * CH_W;
    localparam int WEIGHT_W = 9;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // Field widths of the clip registers
    localparam int TOTAL_W = 16;
    localparam int REQ_W   = 8;
    localparam int FPIX_W  = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd2;

    // Per-request decision handed from the sequencer to the datapath
    typedef struct packed {
        logic                store;
        logic                blend;
        logic                last;
        logic [ADDR_W-1:0]   addr;
        logic [WEIGHT_W-1:0] weight;
    } item_ctrl_t;

    // Q1.8 start weight (and per-frame step) for a given fade length
    function automatic logic [WEIGHT_W-1:0] start_weight(input logic [FADE_W-1:0] t);
        logic [WEIGHT_W-1:0] w;
        begin
            unique case (t)
                3'd1:    w = 9'd128;
                3'd2:    w = 9'd90;
                3'd3:    w = 9'd64;
                3'd4:    w = 9'd51;
                3'd5:    w = 9'd38;
                default: w = 9'd0;
            endcase
            return w;
        end
    endfunction

    // Fade length after clamping against the clip length and the store size
    function automatic logic [FADE_W-1:0] effective_fade(input logic [TOTAL_W-1:0] total,
                                                        input logic [REQ_W-1:0]   req);
        logic [REQ_W-1:0] t;
        begin
            t = req;
            if ({8'd0, req} > total)
                t = REQ_W'(total - 16'd1);
            if (32'(t) > 32'(MAX_FADE_FRAMES))
                t = REQ_W'(MAX_FADE_FRAMES);
            return FADE_W'(t);
        end
    endfunction

endpackage

@@ design/lcb_ram.sv @@
module lcb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lcb_seq.sv @@
module lcb_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    input  logic                             frame_end,
    output lcb_pkg::item_ctrl_t              ctrl
);

    logic [lcb_pkg::TOTAL_W-1:0]   total_frames_reg, total_frames_next;
    logic [lcb_pkg::REQ_W-1:0]     transition_reg, transition_next;
    logic [lcb_pkg::FPIX_W-1:0]    frame_pixels_reg, frame_pixels_next;
    logic [lcb_pkg::FADE_W-1:0]    fade_len_reg, fade_len_next;
    logic [lcb_pkg::TOTAL_W-1:0]   frame_pos_reg, frame_pos_next;
    logic [lcb_pkg::PIX_IDX_W-1:0] pixel_index_reg, pixel_index_next;
    logic [lcb_pkg::WEIGHT_W-1:0]  blend_weight_reg, blend_weight_next;
    logic [lcb_pkg::WEIGHT_W-1:0]  weight_step_reg, weight_step_next;

    logic                          cfg_hit;
    logic [lcb_pkg::SIZE_W-1:0]    size;
    logic [lcb_pkg::SIZE_W-1:0]    pix_ext;
    logic [lcb_pkg::SIZE_W-1:0]    pix;
    logic [lcb_pkg::SIZE_W:0]      pix_inc;
    logic                          store;
    logic                          blend;
    logic                          last;
    logic [lcb_pkg::TOTAL_W:0]     pos_plus_fade;
    logic [lcb_pkg::TOTAL_W:0]     rank_diff;
    logic [lcb_pkg::FADE_W-1:0]    rank;
    logic [lcb_pkg::FADE_W-1:0]    frame_sel;
    logic [lcb_pkg::WEIGHT_W:0]    weight_sum;

    // effective frame size: zero acts as one, oversize clamps to the store row
    always_comb
    begin
        if (frame_pixels_reg == '0)
        begin
            size = lcb_pkg::SIZE_W'(1);
        end
        else if (32'(frame_pixels_reg) > 32'(lcb_pkg::FRAME_PIXELS_MAX))
        begin
            size = lcb_pkg::SIZE_W'(lcb_pkg::FRAME_PIXELS_MAX);
        end
        else
        begin
            size = lcb_pkg::SIZE_W'(frame_pixels_reg);
        end
    end

    // pixel position within the frame and end-of-frame detection
    assign pix_ext = lcb_pkg::SIZE_W'(pixel_index_reg);
    assign pix     = (pix_ext >= size) ? size - lcb_pkg::SIZE_W'(1) : pix_ext;
    assign pix_inc = {1'b0, pix} + (lcb_pkg::SIZE_W+1)'(1);
    assign last    = frame_end || (pix_inc >= {1'b0, size});

    // store, blend or pass
    assign pos_plus_fade = {1'b0, frame_pos_reg} + (lcb_pkg::TOTAL_W+1)'(fade_len_reg);
    assign store = (frame_pos_reg < lcb_pkg::TOTAL_W'(fade_len_reg));
    assign blend = !store && (fade_len_reg != '0)
                   && (pos_plus_fade >= {1'b0, total_frames_reg})
                   && (frame_pos_reg < total_frames_reg);

    // rank of the stored frame that this frame fades against
    assign rank_diff = pos_plus_fade - {1'b0, total_frames_reg};
    assign rank = (32'(rank_diff) >= 32'(lcb_pkg::MAX_FADE_FRAMES))
                  ? lcb_pkg::FADE_W'(lcb_pkg::MAX_FADE_FRAMES - 1)
                  : lcb_pkg::FADE_W'(rank_diff);
    assign frame_sel = store ? lcb_pkg::FADE_W'(frame_pos_reg) : rank;

    assign ctrl.store  = store;
    assign ctrl.blend  = blend;
    assign ctrl.last   = last;
    assign ctrl.weight = blend_weight_reg;
    assign ctrl.addr   = lcb_pkg::ADDR_W'(32'(frame_sel) * 32'(lcb_pkg::FRAME_PIXELS_MAX)
                                          + 32'(pix));

    // weight after a blended frame, saturating at one
    always_comb
    begin
        weight_sum = {1'b0, blend_weight_reg} + {1'b0, weight_step_reg};
        if (weight_sum > {1'b0, lcb_pkg::WEIGHT_ONE})
        begin
            weight_sum = {1'b0, lcb_pkg::WEIGHT_ONE};
        end
    end

    // register decode
    always_comb
    begin
        total_frames_next = total_frames_reg;
        transition_next   = transition_reg;
        frame_pixels_next = frame_pixels_reg;
        cfg_hit           = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                lcb_pkg::REG_TOTAL_FRAMES:
                begin
                    total_frames_next = cfg_data[lcb_pkg::TOTAL_W-1:0];
                    cfg_hit           = 1'b1;
                end
                lcb_pkg::REG_TRANSITION:
                begin
                    transition_next = cfg_data[lcb_pkg::REQ_W-1:0];
                    cfg_hit         = 1'b1;
                end
                lcb_pkg::REG_FRAME_PIXELS:
                begin
                    frame_pixels_next = cfg_data[lcb_pkg::FPIX_W-1:0];
                    cfg_hit           = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // clip sequencing: a write to one of the three clip registers restarts the clip
    always_comb
    begin
        fade_len_next     = fade_len_reg;
        frame_pos_next    = frame_pos_reg;
        pixel_index_next  = pixel_index_reg;
        blend_weight_next = blend_weight_reg;
        weight_step_next  = weight_step_reg;
        if (cfg_hit)
        begin
            fade_len_next     = lcb_pkg::effective_fade(total_frames_next, transition_next);
            frame_pos_next    = '0;
            pixel_index_next  = '0;
            blend_weight_next = lcb_pkg::start_weight(fade_len_next);
            weight_step_next  = lcb_pkg::start_weight(fade_len_next);
        end
        else if (accept)
        begin
            if (last)
            begin
                pixel_index_next = '0;
                if (frame_pos_reg != '1)
                begin
                    frame_pos_next = frame_pos_reg + lcb_pkg::TOTAL_W'(1);
                end
                if (blend)
                begin
                    blend_weight_next = lcb_pkg::WEIGHT_W'(weight_sum);
                end
            end
            else
            begin
                pixel_index_next = lcb_pkg::PIX_IDX_W'(pix_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg <= lcb_pkg::TOTAL_W'(1);
            transition_reg   <= '0;
            frame_pixels_reg <= lcb_pkg::FPIX_W'(65536);
            fade_len_reg     <= lcb_pkg::effective_fade(lcb_pkg::TOTAL_W'(1), '0);
            frame_pos_reg    <= '0;
            pixel_index_reg  <= '0;
            blend_weight_reg <= lcb_pkg::start_weight(
                                    lcb_pkg::effective_fade(lcb_pkg::TOTAL_W'(1), '0));
            weight_step_reg  <= lcb_pkg::start_weight(
                                    lcb_pkg::effective_fade(lcb_pkg::TOTAL_W'(1), '0));
        end
        else
        begin
            total_frames_reg <= total_frames_next;
            transition_reg   <= transition_next;
            frame_pixels_reg <= frame_pixels_next;
            fade_len_reg     <= fade_len_next;
            frame_pos_reg    <= frame_pos_next;
            pixel_index_reg  <= pixel_index_next;
            blend_weight_reg <= blend_weight_next;
            weight_step_reg  <= weight_step_next;
        end
    end

endmodule

@@ design/lcb_lane.sv @@
module lcb_lane (
    input  logic [lcb_pkg::CH_W-1:0]     stored,
    input  logic [lcb_pkg::CH_W-1:0]     live,
    input  logic [lcb_pkg::WEIGHT_W-1:0] weight,
    output logic [lcb_pkg::CH_W-1:0]     mixed
);

    logic [lcb_pkg::WEIGHT_W-1:0] weight_inv;
    logic [16:0]                  sum;

    // stored*w + live*(1-w), rounded to nearest, Q1.8
    assign weight_inv = lcb_pkg::WEIGHT_ONE - weight;
    assign sum = 17'(stored) * 17'(weight) + 17'(live) * 17'(weight_inv) + 17'd128;
    assign mixed = sum[15:8];

endmodule

@@ design/loop_crossfade_blender.sv @@
// Pipeline: an accepted pixel request goes through the frame store registered read
//   and stage one, then the lane blend into the output register.
// Throughput: one pixel per clock unless result_ready stalls the output, set by the
//   lane multipliers and the one read and one write port of the frame store.
// Reset: control, counters and clip registers return to their reset values at once;
//   the frame store is not cleared and holds whatever it held.
module loop_crossfade_blender (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [7:0]                     pixel_ch0,
    input  logic [7:0]                     pixel_ch1,
    input  logic [7:0]                     pixel_ch2,
    input  logic                           frame_end,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [7:0]                     out_ch0,
    output logic [7:0]                     out_ch1,
    output logic [7:0]                     out_ch2,
    output logic                           out_frame_end,
    output logic                           was_blended
);

    lcb_pkg::item_ctrl_t ctrl;

    logic                           accept;
    logic                           ram_we;
    logic                           ram_re;
    logic [lcb_pkg::PIXEL_W-1:0]    ram_rdata;
    logic [lcb_pkg::PIXEL_W-1:0]    mixed;
    logic                           s1_load;
    logic                           s1_move;
    logic                           out_free;

    logic                           s1_valid_reg, s1_valid_next;
    logic [lcb_pkg::PIXEL_W-1:0]    s1_live_reg;
    logic                           s1_last_reg;
    logic                           s1_blend_reg;
    logic [lcb_pkg::WEIGHT_W-1:0]   s1_weight_reg;

    logic                           res_valid_reg, res_valid_next;
    logic [lcb_pkg::PIXEL_W-1:0]    res_pixel_reg;
    logic                           res_last_reg;
    logic                           res_blend_reg;

    // handshake and stage flow
    assign out_free    = !res_valid_reg || result_ready;
    assign pixel_ready = !s1_valid_reg || out_free;
    assign accept      = pixel_valid && pixel_ready;
    assign s1_move     = s1_valid_reg && out_free;
    assign s1_load     = accept && !ctrl.store;

    // clip sequencer
    lcb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .frame_end (frame_end),
        .ctrl      (ctrl)
    );

    // frame store: written for leading frames, read for fade frames
    assign ram_we = accept && ctrl.store;
    assign ram_re = accept && ctrl.blend;

    lcb_ram #(
        .WIDTH (lcb_pkg::PIXEL_W),
        .DEPTH (lcb_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ctrl.addr),
        .wdata ({pixel_ch2, pixel_ch1, pixel_ch0}),
        .re    (ram_re),
        .raddr (ctrl.addr),
        .rdata (ram_rdata)
    );

    // one blend lane per colour channel
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        lcb_lane u_lane (
            .stored (ram_rdata[i*lcb_pkg::CH_W +: lcb_pkg::CH_W]),
            .live   (s1_live_reg[i*lcb_pkg::CH_W +: lcb_pkg::CH_W]),
            .weight (s1_weight_reg),
            .mixed  (mixed[i*lcb_pkg::CH_W +: lcb_pkg::CH_W])
        );
    end

    // stage valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_move)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload: stage one holds the live pixel, output stage merges the lanes
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_live_reg   <= {pixel_ch2, pixel_ch1, pixel_ch0};
            s1_last_reg   <= ctrl.last;
            s1_blend_reg  <= ctrl.blend;
            s1_weight_reg <= ctrl.weight;
        end
        if (s1_move)
        begin
            res_pixel_reg <= s1_blend_reg ? mixed : s1_live_reg;
            res_last_reg  <= s1_last_reg;
            res_blend_reg <= s1_blend_reg;
        end
    end

    assign result_valid  = res_valid_reg;
    assign out_ch0       = res_pixel_reg[7:0];
    assign out_ch1       = res_pixel_reg[15:8];
    assign out_ch2       = res_pixel_reg[23:16];
    assign out_frame_end = res_last_reg;
    assign was_blended   = res_blend_reg;

    // a held stage-one request is never overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |-> !accept)
        else $error("stage one overwritten while stalled");

    // a pixel is either stored or blended, never both
    a_store_xor_blend: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(ctrl.store && ctrl.blend))
        else $error("pixel both stored and blended");

    // a blended request leaving stage one shows up flagged as blended
    a_blend_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_blend_reg) |=> (result_valid && was_blended))
        else $error("blended request lost its flag");

    // stored pixels never enter the output pipeline
    a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctrl.store && !s1_valid_reg) |=> !s1_valid_reg)
        else $error("stored pixel produced a result");

endmodule

@@ sim/loop_crossfade_blender_test.sv @@
`timescale 1ns / 100ps

module loop_crossfade_blender_test;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 560;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 6;    // pipeline tail plus margin
    localparam int MAX_SHOWN    = 10;
    localparam int MAX_GAP      = 4;
    localparam logic [lcb_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       frame_end;
        logic       blended;
    } out_pixel_t;

    // Block ports
    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_write     = 1'b0;
    logic [lcb_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [lcb_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
    logic                           pixel_valid   = 1'b0;
    logic                           pixel_ready;
    logic [7:0]                     pixel_ch0     = 8'h00;
    logic [7:0]                     pixel_ch1     = 8'h00;
    logic [7:0]                     pixel_ch2     = 8'h00;
    logic                           frame_end     = 1'b0;
    logic                           result_valid;
    logic                           result_ready  = 1'b0;
    logic [7:0]                     out_ch0;
    logic [7:0]                     out_ch1;
    logic [7:0]                     out_ch2;
    logic                           out_frame_end;
    logic                           was_blended;

    // Predictor copy of the clip registers and counters
    logic [15:0]  clip_frames;
    logic [7:0]   fade_req;
    logic [16:0]  frame_pix_reg;
    int unsigned  fade_frames;
    int unsigned  frame_no;
    int unsigned  pix_no;
    int unsigned  mix_weight;
    int unsigned  mix_step;
    logic [23:0]  fade_store [int unsigned];
    out_pixel_t   pixels_due [$];

    // Run bookkeeping
    int unsigned  errors;
    int unsigned  n_pixels;
    int unsigned  n_results;
    int unsigned  n_blended;
    int unsigned  n_clips;

    loop_crossfade_blender u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_ch0     (pixel_ch0),
        .pixel_ch1     (pixel_ch1),
        .pixel_ch2     (pixel_ch2),
        .frame_end     (frame_end),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .out_ch0       (out_ch0),
        .out_ch1       (out_ch1),
        .out_ch2       (out_ch2),
        .out_frame_end (out_frame_end),
        .was_blended   (was_blended)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Q1.8 first weight, also the per-frame increment
    function automatic int unsigned weight_for(input int unsigned t);
        case (t)
            1:       return 128;
            2:       return 90;
            3:       return 64;
            4:       return 51;
            5:       return 38;
            default: return 0;
        endcase
    endfunction

    // Fade length: request, else clip length minus one (low byte), capped at store size
    function automatic int unsigned fade_length();
        int unsigned t;
        logic [15:0] tail;
        t    = fade_req;
        tail = clip_frames - 16'd1;
        if (t > clip_frames)
            t = tail[7:0];
        if (t > lcb_pkg::MAX_FADE_FRAMES)
            t = lcb_pkg::MAX_FADE_FRAMES;
        return t;
    endfunction

    function automatic int unsigned frame_size();
        if (frame_pix_reg == 17'd0)
            return 1;
        if (frame_pix_reg > lcb_pkg::FRAME_PIXELS_MAX)
            return lcb_pkg::FRAME_PIXELS_MAX;
        return frame_pix_reg;
    endfunction

    function automatic void restart_clip();
        fade_frames = fade_length();
        frame_no    = 0;
        pix_no      = 0;
        mix_weight  = weight_for(fade_frames);
        mix_step    = mix_weight;
        n_clips++;
    endfunction

    function automatic logic [7:0] lane_mix(input logic [7:0] kept, input logic [7:0] live,
                                            input int unsigned w);
        int unsigned acc;
        acc = kept * w + live * (256 - w) + 128;
        return 8'(acc >> 8);
    endfunction

    // Current frame is one of the last fade frames of the clip
    function automatic bit fade_frame_now();
        return fade_frames != 0 && frame_no >= fade_frames && frame_no < clip_frames &&
               frame_no + fade_frames >= clip_frames;
    endfunction

    // The stored frame has no pixel beyond this one, so the live frame must close here
    function automatic bit store_runs_out();
        int unsigned next_addr;
        next_addr = (frame_no + fade_frames - clip_frames) * lcb_pkg::FRAME_PIXELS_MAX
                    + pix_no + 1;
        return fade_frame_now() && pix_no + 1 < frame_size() && !fade_store.exists(next_addr);
    endfunction

    // Advance the predictor by one accepted pixel and queue the pixel it should emit
    function automatic void crossfade_predict(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic fe);
        int unsigned size;
        int unsigned pix;
        int unsigned k;
        logic [23:0] kept;
        bit          last;
        bit          mixing;
        out_pixel_t  px;
        size   = frame_size();
        pix    = (pix_no >= size) ? size - 1 : pix_no;
        last   = fe || (pix + 1 >= size);
        mixing = fade_frame_now();
        if (frame_no < fade_frames)
        begin
            fade_store[frame_no * lcb_pkg::FRAME_PIXELS_MAX + pix] = {c2, c1, c0};
        end
        else
        begin
            px = '{c0, c1, c2, last, mixing};
            if (mixing)
            begin
                k      = frame_no + fade_frames - clip_frames;
                kept   = fade_store[k * lcb_pkg::FRAME_PIXELS_MAX + pix];
                px.ch0 = lane_mix(kept[7:0], c0, mix_weight);
                px.ch1 = lane_mix(kept[15:8], c1, mix_weight);
                px.ch2 = lane_mix(kept[23:16], c2, mix_weight);
                n_blended++;
            end
            pixels_due.insert(pixels_due.size(), px);
        end
        if (last)
        begin
            pix_no = 0;
            if (frame_no < 65535)
                frame_no++;
            if (mixing)
            begin
                mix_weight += mix_step;
                if (mix_weight > 256)
                    mix_weight = 256;
            end
        end
        else
        begin
            pix_no = pix + 1;
        end
    endfunction

    function automatic void note_error(input string what);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("[%0t] %s", $time, what);
    endfunction

    // One pixel request: optional idle gap, hold valid until accepted, then predict
    task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic fe);
        int unsigned gap;
        logic        fe_out;
        gap    = $urandom_range(0, MAX_GAP);
        fe_out = fe | store_runs_out();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_ch0   <= c0;
        pixel_ch1   <= c1;
        pixel_ch2   <= c2;
        frame_end   <= fe_out;
        do @(posedge clk); while (!pixel_ready);
        crossfade_predict(c0, c1, c2, fe_out);
        n_pixels++;
    endtask

    // Stop sending and let every queued pixel come out, plus the pipeline tail
    task automatic drain_results();
        pixel_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lcb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcb_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            lcb_pkg::REG_TOTAL_FRAMES: clip_frames   = value[15:0];
            lcb_pkg::REG_TRANSITION:   fade_req      = value[7:0];
            lcb_pkg::REG_FRAME_PIXELS: frame_pix_reg = value[16:0];
            default:                   return;
        endcase
        restart_clip();
    endtask

    // Compare one accepted result with the oldest queued pixel
    task automatic check_pixel();
        out_pixel_t got;
        out_pixel_t want;
        got = '{out_ch0, out_ch1, out_ch2, out_frame_end, was_blended};
        n_results++;
        if (pixels_due.size() == 0)
        begin
            note_error($sformatf("unexpected result ch %02h %02h %02h end %0b mix %0b",
                                 got.ch0, got.ch1, got.ch2, got.frame_end, got.blended));
        end
        else
        begin
            want = pixels_due.pop_front();
            if (got.ch0 !== want.ch0 || got.ch1 !== want.ch1 || got.ch2 !== want.ch2 ||
                got.frame_end !== want.frame_end || got.blended !== want.blended)
                note_error($sformatf({"result %0d: ch %02h %02h %02h end %0b mix %0b, ",
                                      "expected ch %02h %02h %02h end %0b mix %0b"},
                                     n_results, got.ch0, got.ch1, got.ch2, got.frame_end,
                                     got.blended, want.ch0, want.ch1, want.ch2,
                                     want.frame_end, want.blended));
        end
    endtask

    // Default registers: clip of one frame, no fade, all pixels pass
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h5A, 8'hA5, 8'h3C, 1'b0);
    endtask

    // Three-frame fade over a six-frame clip with opposite extremes stored and live
    task automatic test_directed_fade();
        logic [7:0] v;
        drain_results();
        write_reg(lcb_pkg::REG_TOTAL_FRAMES, 17'd6);
        write_reg(lcb_pkg::REG_TRANSITION, 17'd3);
        write_reg(lcb_pkg::REG_FRAME_PIXELS, 17'd2);
        for (int f = 0; f < 7; f++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                v = ((f + i) % 2 != 0) ? 8'hFF : 8'h00;
                send_pixel(v, ~v, 8'(f * 40), 1'b0);
            end
        end
    endtask

    task automatic test_special_cases();
        // zero frame size acts as one pixel; a request above the clip length drops to length - 1
        drain_results();
        write_reg(lcb_pkg::REG_TOTAL_FRAMES, 17'd4);
        write_reg(lcb_pkg::REG_TRANSITION, 17'd9);
        write_reg(lcb_pkg::REG_FRAME_PIXELS, 17'd0);
        repeat (5) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        // empty clip: fade clamps to the store size, nothing is ever blended
        drain_results();
        write_reg(lcb_pkg::REG_TOTAL_FRAMES, 17'd0);
        write_reg(lcb_pkg::REG_TRANSITION, 17'd255);
        write_reg(lcb_pkg::REG_FRAME_PIXELS, 17'd1);
        repeat (6) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        // spare index: no restart, the clip carries on past the stored frames
        drain_results();
        write_reg(REG_SPARE, 17'h1FFFF);
        repeat (2) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    endtask

    // Mostly short complete clips with random content; some cut short or oddly sized
    task automatic test_random_clips();
        int unsigned sent;
        int unsigned clips;
        int unsigned in_clip;
        int unsigned tot;
        int unsigned req;
        int unsigned fp;
        int unsigned frames_wanted;
        int unsigned end_odds;
        bit          fp_first;
        sent  = 0;
        clips = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       tot = $urandom_range(13, 65535);
                1:       tot = 0;
                default: tot = $urandom_range(1, 12);
            endcase
            req = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0:       fp = 0;
                1:       fp = $urandom_range(7, 131071);
                default: fp = $urandom_range(1, 6);
            endcase
            fp_first = $urandom_range(0, 1);
            if (fp_first)
                write_reg(lcb_pkg::REG_FRAME_PIXELS, 17'(fp));
            write_reg(lcb_pkg::REG_TOTAL_FRAMES, {1'($urandom), 16'(tot)});
            write_reg(lcb_pkg::REG_TRANSITION, {9'($urandom), 8'(req)});
            if (!fp_first)
                write_reg(lcb_pkg::REG_FRAME_PIXELS, 17'(fp));
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_SPARE, 17'($urandom));

            frames_wanted = ((tot < 14) ? tot : 14) + $urandom_range(0, 2);
            end_odds      = (fp > 6 || fp == 0) ? 2 : 5;
            in_clip       = 0;
            while (frame_no < frames_wanted && in_clip < 60 && sent < RANDOM_ITEMS)
            begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(0, end_odds) == 0);
                in_clip++;
                sent++;
                // sender holds off mid-clip until the output side has caught up
                if (in_clip == 5 && (clips == 0 || $urandom_range(0, 3) == 0))
                    drain_results();
            end
            clips++;
        end
    endtask

    // Oversized frame register: short frames closed by the end flag, the last faded
    task automatic test_oversize_frame();
        drain_results();
        write_reg(lcb_pkg::REG_TOTAL_FRAMES, 17'd3);
        write_reg(lcb_pkg::REG_TRANSITION, 17'd1);
        write_reg(lcb_pkg::REG_FRAME_PIXELS, 17'h1FFFF);
        for (int f = 0; f < 3; f++)
        begin
            for (int i = 0; i < 4; i++)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 3);
        end
    endtask

    // Output side: random stall before each result, then accept and check
    initial
    begin : result_side
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
            check_pixel();
        end
    end

    // Ends the run when neither channel nor the register port has moved for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (pixel_valid && pixel_ready) ||
                (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Stalled for %0d cycles with %0d results outstanding",
                 QUIET_LIMIT, pixels_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        errors        = 0;
        n_pixels      = 0;
        n_results     = 0;
        n_blended     = 0;
        n_clips       = 0;
        clip_frames   = 16'd1;
        fade_req      = 8'd0;
        frame_pix_reg = 17'h10000;
        restart_clip();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_fade();
        test_special_cases();
        test_random_clips();
        test_oversize_frame();
        drain_results();

        $display("Sent %0d pixel requests across %0d clip restarts; %0d checked, %0d faded.",
                 n_pixels, n_clips, n_results, n_blended);
        $display("Covered clamped registers, zero and oversize frames, store-limited frames.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
design/lcb_pkg.sv
design/lcb_ram.sv
design/lcb_seq.sv
design/lcb_lane.sv
design/loop_crossfade_blender.sv
sim/loop_crossfade_blender_test.sv
